/* design/hsl_pkg.sv */
// ----------------------------------------------------------------------------
// hsl_pkg: shared types, constants and tables for the hsl to rgb converter
// Fixed point format, ramp segment codes, queue sizing and the constant
// tables that turn 8-bit fractions and hue degrees into fixed point.
// ----------------------------------------------------------------------------
`default_nettype none

package hsl_pkg;

    // fixed point format: FRAC_BITS fraction bits, one extra bit holds 1.0
    localparam int FRAC_BITS = 16;
    localparam int FX_W      = FRAC_BITS + 1;

    typedef logic [FX_W-1:0] t_fx;

    localparam longint ONE_L = longint'(1) << FRAC_BITS;

    localparam t_fx FX_ONE        = t_fx'(ONE_L);
    localparam t_fx FX_HALF       = t_fx'(ONE_L / 2);
    localparam t_fx FX_THIRD      = t_fx'((ONE_L + 1) / 3);
    localparam t_fx FX_SIXTH      = t_fx'((ONE_L + 3) / 6);
    localparam t_fx FX_TWO_THIRDS = t_fx'((2 * ONE_L + 1) / 3);

    // hue range handling
    localparam logic [8:0] HUE_TURN  = 9'd360;
    localparam logic [8:0] HUE_HALF  = 9'd180;
    localparam int         HUE_TAB_N = 180;

    // channel count and queue sizing
    localparam int CH_N    = 3;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef t_fx t_tab_frac [0:255];
    typedef t_fx t_tab_hue  [0:HUE_TAB_N-1];

    // round(i * ONE / 255) for every 8-bit code
    function automatic t_tab_frac build_frac_tab();
        t_tab_frac tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = t_fx'((longint'(i) * ONE_L + 127) / 255);
        end
        return tab;
    endfunction

    // round(deg * ONE / 360) for one half turn starting at base
    function automatic t_tab_hue build_hue_tab(input int base);
        t_tab_hue tab;
        for (int i = 0; i < HUE_TAB_N; i++) begin
            tab[i] = t_fx'((longint'(i + base) * ONE_L + 180) / 360);
        end
        return tab;
    endfunction

    localparam t_tab_frac FRAC_TAB   = build_frac_tab();
    localparam t_tab_hue  HUE_LO_TAB = build_hue_tab(0);
    localparam t_tab_hue  HUE_HI_TAB = build_hue_tab(HUE_TAB_N);

    // piecewise hue ramp segments
    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_TOP,
        SEG_FALL,
        SEG_LOW
    } t_seg;

    typedef struct packed {
        t_seg seg;
        t_fx  mul;
    } t_ramp;

    // fields that ride along with an item untouched
    typedef struct packed {
        logic       gray;
        logic [7:0] lit;
        logic [7:0] alpha;
    } t_pass;

    // classified item as it sits in the queue
    typedef struct packed {
        t_pass pass;
        t_fx   s;
        t_fx   l;
        t_fx   h;
    } t_item;

endpackage

`default_nettype wire

/* design/hsl_to_rgb_convert.sv */
// An accepted item passes the front register, the queue and the seven back stages.
// throughput: one item per cycle unless stalled; the front register holds while
//   the four-entry queue is full, the seven-stage back pipeline on output stall
// reset: synchronous active low; clears valids and queue pointers, no items held
// ----------------------------------------------------------------------------
// hsl_to_rgb_convert: hue, saturation, lightness to red, green, blue
// Front stage classifies items, a queue decouples it from the arithmetic
// pipeline, whose last stage is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hsl_to_rgb_convert (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [8:0]  i_hue_deg,
    input  wire  [7:0]  i_saturation,
    input  wire  [7:0]  i_lightness,
    input  wire  [7:0]  i_alpha_in,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha_out
);
    import hsl_pkg::*;

    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_empty;
    t_item  q_in;
    t_item  q_out;

    // classification front
    hsl_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_hue_deg    (i_hue_deg),
        .i_saturation (i_saturation),
        .i_lightness  (i_lightness),
        .i_alpha_in   (i_alpha_in),
        .o_push       (q_push),
        .o_item       (q_in),
        .i_full       (q_full)
    );

    // decoupling queue
    hsl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    // arithmetic back end
    hsl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_item      (q_out),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue),
        .o_alpha_out (o_alpha_out)
    );

endmodule

`default_nettype wire

/* design/hsl_fifo.sv */
// ----------------------------------------------------------------------------
// hsl_fifo: item queue between front and back
// Small register queue; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hsl_fifo (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  hsl_pkg::t_item  i_data,
    output logic            o_full,
    input  wire             i_pop,
    output logic            o_empty,
    output hsl_pkg::t_item  o_data
);
    import hsl_pkg::*;

    t_item             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr, n_wr;
    logic [Q_AW-1:0]   r_rd, n_rd;
    logic [Q_AW:0]     r_cnt, n_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    // pointer and count update
    always_comb begin
        n_wr  = i_push ? r_wr + 1'b1 : r_wr;
        n_rd  = i_pop  ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (Q_AW+1)'(Q_DEPTH))
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

/* design/hsl_front.sv */
// ----------------------------------------------------------------------------
// hsl_front: input side of the hsl to rgb converter
// Accepts an item, wraps the hue, flags gray items and looks up the fixed
// point saturation, lightness and hue before handing the item to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hsl_front (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_stall,
    input  wire  [8:0]      i_hue_deg,
    input  wire  [7:0]      i_saturation,
    input  wire  [7:0]      i_lightness,
    input  wire  [7:0]      i_alpha_in,
    output logic            o_push,
    output hsl_pkg::t_item  o_item,
    input  wire             i_full
);
    import hsl_pkg::*;

    logic        r_vld, n_vld;
    t_item       r_item;
    t_item       n_item;
    logic        accept;
    logic [8:0]  hue_m;
    logic [8:0]  hue_lo;
    logic [7:0]  hue_idx;
    logic        hue_upper;

    assign o_stall = r_vld && i_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_vld && !i_full;
    assign o_item  = r_item;

    // hue wrap and table lookups
    always_comb begin
        hue_m     = (i_hue_deg >= HUE_TURN) ? i_hue_deg - HUE_TURN : i_hue_deg;
        hue_upper = (hue_m >= HUE_HALF);
        hue_lo    = hue_upper ? hue_m - HUE_HALF : hue_m;
        hue_idx   = hue_lo[7:0];

        n_item.pass.gray  = (i_saturation == 8'd0);
        n_item.pass.lit   = i_lightness;
        n_item.pass.alpha = i_alpha_in;
        n_item.s          = FRAC_TAB[i_saturation];
        n_item.l          = FRAC_TAB[i_lightness];
        n_item.h          = hue_upper ? HUE_HI_TAB[hue_idx] : HUE_LO_TAB[hue_idx];
    end

    // holding register valid
    always_comb begin
        n_vld = accept || (r_vld && i_full);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

/* design/hsl_back.sv */
// ----------------------------------------------------------------------------
// hsl_back: arithmetic pipeline of the hsl to rgb converter
// Seven stages: l*s product and hue offsets, q and ramp segments, p,
// spread q-p, ramp products, channel value, scaling to 8 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module hsl_back (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_empty,
    input  hsl_pkg::t_item  i_item,
    output logic            o_pop,
    output logic            o_valid,
    input  wire             i_stall,
    output logic [7:0]      o_red,
    output logic [7:0]      o_green,
    output logic [7:0]      o_blue,
    output logic [7:0]      o_alpha_out
);
    import hsl_pkg::*;

    // segment and multiplier operand for one ramp point
    function automatic t_ramp classify(input t_fx t);
        t_ramp           r;
        t_fx             diff;
        logic [FX_W+2:0] six;
        r.seg = SEG_LOW;
        r.mul = '0;
        diff  = '0;
        six   = '0;
        if (t < FX_SIXTH) begin
            r.seg = SEG_RISE;
            six   = ({3'b000, t} << 2) + ({3'b000, t} << 1);
            r.mul = six[FX_W-1:0];
        end else if (t < FX_HALF) begin
            r.seg = SEG_TOP;
        end else if (t < FX_TWO_THIRDS) begin
            r.seg = SEG_FALL;
            diff  = FX_TWO_THIRDS - t;
            six   = ({3'b000, diff} << 2) + ({3'b000, diff} << 1);
            r.mul = six[FX_W-1:0];
        end
        return r;
    endfunction

    logic [7:1]  r_vld;
    logic        adv;
    t_pass       r_pass [1:6];

    // stage registers
    t_fx         r1_l, r1_s, r1_ls;
    t_fx         r1_t [CH_N];
    t_fx         r2_l, r2_q;
    t_ramp       r2_rmp [CH_N];
    t_fx         r3_p, r3_q;
    t_ramp       r3_rmp [CH_N];
    t_fx         r4_d, r4_p, r4_q;
    t_ramp       r4_rmp [CH_N];
    t_fx         r5_p, r5_q;
    t_fx         r5_rp [CH_N];
    t_seg        r5_seg [CH_N];
    t_fx         r6_v [CH_N];
    logic [7:0]  r7_ch [CH_N];
    logic [7:0]  r7_alpha;

    // combinational values per stage
    logic [2*FX_W-1:0] ls_prod, ls_rnd;
    logic [FX_W:0]     tr_sum;
    t_fx               n1_t [CH_N];
    t_fx               n1_ls;
    logic [FX_W:0]     q_a, q_b, q_raw;
    t_fx               n2_q;
    t_ramp             n2_rmp [CH_N];
    logic [FX_W+1:0]   p_raw;
    t_fx               n3_p;
    logic [2*FX_W-1:0] dm_prod [CH_N];
    logic [2*FX_W-1:0] dm_rnd [CH_N];
    logic [FX_W:0]     v_sum [CH_N];
    logic [FX_W:0]     v_sel [CH_N];
    logic [FX_W+8:0]   ch_full [CH_N];

    assign adv     = !(r_vld[7] && i_stall);
    assign o_pop   = adv && !i_empty;
    assign o_valid = r_vld[7];
    assign o_red       = r7_ch[0];
    assign o_green     = r7_ch[1];
    assign o_blue      = r7_ch[2];
    assign o_alpha_out = r7_alpha;

    // stage 1: rounded l*s and the three hue points
    always_comb begin
        ls_prod = i_item.l * i_item.s;
        ls_rnd  = ls_prod + {{FX_W{1'b0}}, FX_HALF};
        n1_ls   = ls_rnd[FRAC_BITS +: FX_W];
        tr_sum  = {1'b0, i_item.h} + {1'b0, FX_THIRD};
        n1_t[0] = (tr_sum > {1'b0, FX_ONE}) ? t_fx'(tr_sum - {1'b0, FX_ONE})
                                            : tr_sum[FX_W-1:0];
        n1_t[1] = i_item.h;
        n1_t[2] = (i_item.h >= FX_THIRD) ? i_item.h - FX_THIRD
                                         : i_item.h + FX_ONE - FX_THIRD;
    end

    // stage 2: q and ramp segments
    always_comb begin
        q_a   = {1'b0, r1_l} + {1'b0, r1_ls};
        q_b   = {1'b0, r1_l} + {1'b0, r1_s} - {1'b0, r1_ls};
        q_raw = (r1_l < FX_HALF) ? q_a : q_b;
        n2_q  = (q_raw > {1'b0, FX_ONE}) ? FX_ONE : q_raw[FX_W-1:0];
        for (int c = 0; c < CH_N; c++) begin
            n2_rmp[c] = classify(r1_t[c]);
        end
    end

    // stage 3: p = 2l - q, kept within zero and q
    always_comb begin
        p_raw = {1'b0, r2_l, 1'b0} - {2'b00, r2_q};
        if (p_raw[FX_W+1]) begin
            n3_p = '0;
        end else if (p_raw[FX_W:0] > {1'b0, r2_q}) begin
            n3_p = r2_q;
        end else begin
            n3_p = p_raw[FX_W-1:0];
        end
    end

    // stage 5: rounded ramp products, stages 6 and 7: value and scaling
    always_comb begin
        for (int c = 0; c < CH_N; c++) begin
            dm_prod[c] = r4_d * r4_rmp[c].mul;
            dm_rnd[c]  = dm_prod[c] + {{FX_W{1'b0}}, FX_HALF};
            v_sum[c]   = {1'b0, r5_p} + {1'b0, r5_rp[c]};
            case (r5_seg[c])
                SEG_RISE: v_sel[c] = v_sum[c];
                SEG_FALL: v_sel[c] = v_sum[c];
                SEG_TOP:  v_sel[c] = {1'b0, r5_q};
                default:  v_sel[c] = {1'b0, r5_p};
            endcase
            ch_full[c] = {1'b0, r6_v[c], 8'd0} - {9'd0, r6_v[c]}
                       + {9'd0, FX_HALF};
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[6:1], !i_empty};
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pass[1] <= i_item.pass;
            for (int k = 2; k <= 6; k++) begin
                r_pass[k] <= r_pass[k-1];
            end

            r1_l  <= i_item.l;
            r1_s  <= i_item.s;
            r1_ls <= n1_ls;
            r2_l  <= r1_l;
            r2_q  <= n2_q;
            r3_p  <= n3_p;
            r3_q  <= r2_q;
            r4_d  <= r3_q - r3_p;
            r4_p  <= r3_p;
            r4_q  <= r3_q;
            r5_p  <= r4_p;
            r5_q  <= r4_q;

            for (int c = 0; c < CH_N; c++) begin
                r1_t[c]   <= n1_t[c];
                r2_rmp[c] <= n2_rmp[c];
                r3_rmp[c] <= r2_rmp[c];
                r4_rmp[c] <= r3_rmp[c];
                r5_seg[c] <= r4_rmp[c].seg;
                r5_rp[c]  <= dm_rnd[c][FRAC_BITS +: FX_W];
                r6_v[c]   <= (v_sel[c] > {1'b0, FX_ONE}) ? FX_ONE
                                                         : v_sel[c][FX_W-1:0];
                r7_ch[c]  <= r_pass[6].gray ? r_pass[6].lit
                                            : ch_full[c][FRAC_BITS +: 8];
            end
            r7_alpha <= r_pass[6].alpha;
        end
    end

`ifndef SYNTHESIS
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[7] && i_stall) |=> $stable(r_vld))
        else $error("pipeline moved while output stalled");

    a_p_not_above_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> (r3_p <= r3_q))
        else $error("p above q");

    a_gray_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[6] && r_pass[6].gray && adv) |=>
        ((r7_ch[0] == r7_ch[1]) && (r7_ch[1] == r7_ch[2])))
        else $error("gray item with unequal channels");
`endif

endmodule

`default_nettype wire
